@@ rtl/ghp_pkg.sv @@
package ghp_pkg;

    // Pool geometry and field widths
    localparam int CAPACITY = 256;
    localparam int SLOT_W   = 8;
    localparam int LINK_W   = SLOT_W + 1;
    localparam int GEN_W    = 16;
    localparam int CMD_W    = 3;

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(CAPACITY);
    localparam logic [GEN_W-1:0]  GEN_MAX   = {GEN_W{1'b1}};
    localparam logic [GEN_W-1:0]  GEN_FIRST = GEN_W'(1);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_AT      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

    // Request word
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic              handle_valid;
        logic [SLOT_W-1:0] slot_num;
        logic [GEN_W-1:0]  generation;
        logic [SLOT_W-1:0] dense_pos;
    } req_t;

    // Response word
    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot_num_res;
        logic [GEN_W-1:0]  generation_res;
        logic [SLOT_W-1:0] dense_pos_res;
        logic [LINK_W-1:0] live_count;
        logic              full_res;
    } rsp_t;

    // One slot entry: link is next free slot, or dense position when live
    typedef struct packed {
        logic [GEN_W-1:0]  gen;
        logic [LINK_W-1:0] link;
        logic              active;
    } slot_word_t;

    // Slot store access for one cycle
    typedef struct packed {
        logic              wr;
        logic [SLOT_W-1:0] waddr;
        slot_word_t        wdata;
        logic [SLOT_W-1:0] raddr;
    } slot_req_t;

    // Entry contents after reset: generation one, chained to the next slot, the last slot ending the chain
    function automatic slot_word_t slot_reset_word(input logic [SLOT_W-1:0] idx);
        slot_word_t w;
        w.gen    = GEN_FIRST;
        w.link   = (idx == SLOT_W'(CAPACITY - 1)) ? LINK_NONE : ({1'b0, idx} + LINK_W'(1));
        w.active = 1'b0;
        return w;
    endfunction

endpackage

@@ rtl/ghp_ram.sv @@
module ghp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ghp_slot_store.sv @@
module ghp_slot_store (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ghp_pkg::slot_req_t    req,
    output ghp_pkg::slot_word_t   rd
);

    import ghp_pkg::*;

    logic [CAPACITY-1:0] written_reg;
    logic [CAPACITY-1:0] written_next;
    logic [SLOT_W-1:0]   rd_addr_reg;
    logic                rd_written_reg;
    logic [$bits(slot_word_t)-1:0] ram_rd;

    ghp_ram #(
        .WIDTH ($bits(slot_word_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (req.wr),
        .wr_addr (req.waddr),
        .wr_data (req.wdata),
        .rd_addr (req.raddr),
        .rd_data (ram_rd)
    );

    // Mark entries once written; unwritten entries read as reset contents
    always_comb
    begin
        written_next = written_reg;
        if (req.wr)
        begin
            written_next[req.waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else
        begin
            written_reg <= written_next;
        end
    end

    // Track the address of the read in flight
    always_ff @(posedge clk)
    begin
        rd_addr_reg    <= req.raddr;
        rd_written_reg <= written_reg[req.raddr];
    end

    assign rd = rd_written_reg ? slot_word_t'(ram_rd) : slot_reset_word(rd_addr_reg);

endmodule

@@ rtl/generational_handle_pool.sv @@
// Generational handle pool with a dense live order. One request word gives
// one response word. Each request is handled alone by a sequencer around two
// single-port-read memories (slot entries and dense owners, registered
// reads), so the cost is counted in memory round trips: create on a full
// pool, unknown commands and handle-at out of range touch no memory, destroy
// takes extra round trips when the last dense entry moves into the hole, and
// clear walks every live entry in dense order. While an earlier response is
// still stalled, a finished response waits in the sequencer. The next request
// is accepted the cycle after the response register loads, even while the
// response still waits.
module generational_handle_pool (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ghp_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ghp_pkg::rsp_t rsp
);

    import ghp_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD     = 4'd1;
    localparam logic [3:0] S_EX     = 4'd2;
    localparam logic [3:0] S_MV_RD  = 4'd3;
    localparam logic [3:0] S_MV_WR  = 4'd4;
    localparam logic [3:0] S_AT_DN  = 4'd5;
    localparam logic [3:0] S_AT_SL  = 4'd6;
    localparam logic [3:0] S_AT_GEN = 4'd7;
    localparam logic [3:0] S_CLR_DN = 4'd8;
    localparam logic [3:0] S_CLR_SL = 4'd9;
    localparam logic [3:0] S_CLR_WR = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0]        state_reg,     state_next;
    logic [CMD_W-1:0]  cmd_reg,       cmd_next;
    logic              hvalid_reg,    hvalid_next;
    logic [SLOT_W-1:0] hslot_reg,     hslot_next;
    logic [GEN_W-1:0]  hgen_reg,      hgen_next;
    logic [SLOT_W-1:0] didx_reg,      didx_next;
    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [LINK_W-1:0] live_reg,      live_next;
    logic [SLOT_W-1:0] hole_reg,      hole_next;
    logic [SLOT_W-1:0] tgt_reg,       tgt_next;
    logic [LINK_W-1:0] clr_idx_reg,   clr_idx_next;
    logic              res_ok_reg,    res_ok_next;
    logic [SLOT_W-1:0] res_slot_reg,  res_slot_next;
    logic [GEN_W-1:0]  res_gen_reg,   res_gen_next;
    logic [SLOT_W-1:0] res_dense_reg, res_dense_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg,       out_next;

    slot_req_t         slot_req;
    slot_word_t        slot_rd;
    logic              dn_wr;
    logic [SLOT_W-1:0] dn_waddr;
    logic [SLOT_W-1:0] dn_wdata;
    logic [SLOT_W-1:0] dn_raddr;
    logic [SLOT_W-1:0] dn_rd;

    logic              accept;
    logic              match;
    logic              exhausted;
    slot_word_t        rel_word;
    logic [LINK_W-1:0] last_pos;
    logic [LINK_W-1:0] clr_inc;

    ghp_slot_store u_slots (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (slot_req),
        .rd    (slot_rd)
    );

    ghp_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CAPACITY)
    ) u_dense (
        .clk     (clk),
        .wr_en   (dn_wr),
        .wr_addr (dn_waddr),
        .wr_data (dn_wdata),
        .rd_addr (dn_raddr),
        .rd_data (dn_rd)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;

    // Handle check and release of the slot just read
    assign match     = hvalid_reg && slot_rd.active && (slot_rd.gen == hgen_reg);
    assign exhausted = (slot_rd.gen == GEN_MAX);
    assign last_pos  = live_reg - LINK_W'(1);
    assign clr_inc   = clr_idx_reg + LINK_W'(1);

    always_comb
    begin
        rel_word.active = 1'b0;
        rel_word.gen    = exhausted ? slot_rd.gen : (slot_rd.gen + GEN_W'(1));
        rel_word.link   = exhausted ? LINK_NONE : free_head_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        hvalid_next    = hvalid_reg;
        hslot_next     = hslot_reg;
        hgen_next      = hgen_reg;
        didx_next      = didx_reg;
        free_head_next = free_head_reg;
        live_next      = live_reg;
        hole_next      = hole_reg;
        tgt_next       = tgt_reg;
        clr_idx_next   = clr_idx_reg;
        res_ok_next    = res_ok_reg;
        res_slot_next  = res_slot_reg;
        res_gen_next   = res_gen_reg;
        res_dense_next = res_dense_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;

        slot_req.wr    = 1'b0;
        slot_req.waddr = hslot_reg;
        slot_req.wdata = rel_word;
        slot_req.raddr = hslot_reg;
        dn_wr          = 1'b0;
        dn_waddr       = hole_reg;
        dn_wdata       = dn_rd;
        dn_raddr       = didx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next       = req.command;
                    hvalid_next    = req.handle_valid;
                    hslot_next     = req.slot_num;
                    hgen_next      = req.generation;
                    didx_next      = req.dense_pos;
                    res_ok_next    = 1'b0;
                    res_slot_next  = '0;
                    res_gen_next   = '0;
                    res_dense_next = '0;
                    clr_idx_next   = '0;
                    case (req.command)
                        CMD_CREATE:
                        begin
                            if (free_head_reg != LINK_NONE && live_reg < LINK_W'(CAPACITY))
                            begin
                                state_next = S_RD;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        CMD_DESTROY, CMD_LOOKUP:
                        begin
                            state_next = S_RD;
                        end
                        CMD_AT:
                        begin
                            state_next = ({1'b0, req.dense_pos} < live_reg) ? S_AT_DN : S_DONE;
                        end
                        CMD_CLEAR:
                        begin
                            if (live_reg == '0)
                            begin
                                res_ok_next = 1'b1;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_CLR_DN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Read the slot named by the free head or the handle
            S_RD:
            begin
                slot_req.raddr = (cmd_reg == CMD_CREATE) ? free_head_reg[SLOT_W-1:0] : hslot_reg;
                if (cmd_reg == CMD_CREATE)
                begin
                    hslot_next = free_head_reg[SLOT_W-1:0];
                end
                state_next = S_EX;
            end

            S_EX:
            begin
                state_next = S_DONE;
                case (cmd_reg)
                    CMD_CREATE:
                    begin
                        slot_req.wr           = 1'b1;
                        slot_req.wdata.gen    = slot_rd.gen;
                        slot_req.wdata.link   = live_reg;
                        slot_req.wdata.active = 1'b1;
                        dn_wr                 = 1'b1;
                        dn_waddr              = live_reg[SLOT_W-1:0];
                        dn_wdata              = hslot_reg;
                        free_head_next        = slot_rd.link;
                        live_next             = live_reg + LINK_W'(1);
                        res_ok_next           = 1'b1;
                        res_slot_next         = hslot_reg;
                        res_gen_next          = slot_rd.gen;
                        res_dense_next        = live_reg[SLOT_W-1:0];
                    end
                    CMD_DESTROY:
                    begin
                        if (match && live_reg != '0)
                        begin
                            slot_req.wr = 1'b1;
                            if (!exhausted)
                            begin
                                free_head_next = {1'b0, hslot_reg};
                            end
                            live_next   = last_pos;
                            res_ok_next = 1'b1;
                            // last dense entry fills the hole
                            if (slot_rd.link < last_pos)
                            begin
                                hole_next  = slot_rd.link[SLOT_W-1:0];
                                dn_raddr   = last_pos[SLOT_W-1:0];
                                state_next = S_MV_RD;
                            end
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        if (match)
                        begin
                            res_ok_next    = 1'b1;
                            res_slot_next  = hslot_reg;
                            res_gen_next   = slot_rd.gen;
                            res_dense_next = slot_rd.link[SLOT_W-1:0];
                        end
                    end
                    default:
                    begin
                        res_ok_next = 1'b0;
                    end
                endcase
            end

            // Moved owner: repoint the dense entry, then fetch its slot
            S_MV_RD:
            begin
                dn_wr          = 1'b1;
                dn_waddr       = hole_reg;
                dn_wdata       = dn_rd;
                slot_req.raddr = dn_rd;
                tgt_next       = dn_rd;
                state_next     = S_MV_WR;
            end

            S_MV_WR:
            begin
                slot_req.wr           = 1'b1;
                slot_req.waddr        = tgt_reg;
                slot_req.wdata.gen    = slot_rd.gen;
                slot_req.wdata.link   = {1'b0, hole_reg};
                slot_req.wdata.active = slot_rd.active;
                state_next            = S_DONE;
            end

            // Handle at a dense position
            S_AT_DN:
            begin
                dn_raddr   = didx_reg;
                state_next = S_AT_SL;
            end

            S_AT_SL:
            begin
                slot_req.raddr = dn_rd;
                tgt_next       = dn_rd;
                state_next     = S_AT_GEN;
            end

            S_AT_GEN:
            begin
                res_ok_next    = 1'b1;
                res_slot_next  = tgt_reg;
                res_gen_next   = slot_rd.gen;
                res_dense_next = didx_reg;
                state_next     = S_DONE;
            end

            // Clear: release owners in dense order
            S_CLR_DN:
            begin
                dn_raddr   = clr_idx_reg[SLOT_W-1:0];
                state_next = S_CLR_SL;
            end

            S_CLR_SL:
            begin
                slot_req.raddr = dn_rd;
                tgt_next       = dn_rd;
                state_next     = S_CLR_WR;
            end

            S_CLR_WR:
            begin
                slot_req.wr    = 1'b1;
                slot_req.waddr = tgt_reg;
                if (!exhausted)
                begin
                    free_head_next = {1'b0, tgt_reg};
                end
                clr_idx_next = clr_inc;
                if (clr_inc == live_reg)
                begin
                    live_next   = '0;
                    res_ok_next = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_CLR_DN;
                end
            end

            // Load the response word once the output register is free
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next.ok             = res_ok_reg;
                    out_next.slot_num_res   = res_slot_reg;
                    out_next.generation_res = res_gen_reg;
                    out_next.dense_pos_res  = res_dense_reg;
                    out_next.live_count     = live_reg;
                    out_next.full_res       = (free_head_reg == LINK_NONE);
                    out_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
            clr_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
            clr_idx_reg   <= clr_idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        hvalid_reg    <= hvalid_next;
        hslot_reg     <= hslot_next;
        hgen_reg      <= hgen_next;
        didx_reg      <= didx_next;
        hole_reg      <= hole_next;
        tgt_reg       <= tgt_next;
        res_ok_reg    <= res_ok_next;
        res_slot_reg  <= res_slot_next;
        res_gen_reg   <= res_gen_next;
        res_dense_reg <= res_dense_next;
        out_reg       <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

`ifndef SYNTH
    // Live count never exceeds the pool
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= LINK_W'(CAPACITY))
        else $error("live count beyond capacity");

    // A response word only appears after the sequencer finishes a request
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response loaded outside completion");

    // The free head never names a live slot
    a_create_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EX && cmd_reg == CMD_CREATE) |-> !slot_rd.active)
        else $error("free list holds an active slot");

    // The entry moved into a hole is live
    a_moved_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MV_WR) |-> slot_rd.active)
        else $error("moved dense entry is not active");
`endif

endmodule
